>>> rtl/core/lucw_pkg.sv
package lucw_pkg;

	// Field widths of the input and result words
	localparam int CHAR_W = 8;
	localparam int LEN_W  = 17;

	// Result queue geometry
	localparam int FIFO_DEPTH = 3;
	localparam int PTR_W      = 2;
	localparam int FILL_W     = 2;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              is_last;
	} in_word_t;

	typedef struct packed {
		logic [LEN_W-1:0] best_length;
		logic [LEN_W-1:0] window_length;
		logic             final_flag;
		logic             overflow;
	} out_word_t;

endpackage

>>> rtl/core/lucw_out_fifo.sv
module lucw_out_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  lucw_pkg::out_word_t          push_word,
	output logic                         pop_valid,
	input  logic                         pop_ready,
	output lucw_pkg::out_word_t          pop_word,
	output logic [lucw_pkg::FILL_W-1:0]  fill
);
	import lucw_pkg::*;

	out_word_t         fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              pop;

	assign pop       = pop_valid && pop_ready;
	assign pop_valid = (fill_q != '0);
	assign pop_word  = fifo_q[rd_ptr_q];
	assign fill      = fill_q;

	// Wrap a pointer at the queue depth
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> rtl/core/longest_unique_char_window.sv
// Result path: a result word is formed in stage one and offered from the result queue.
// Throughput: one byte per cycle while the result queue has room; the last-seen
// table is a one-port-read, one-port-write RAM with a registered read, and a
// back-to-back repeat of the same byte is served by a forwarding register.
// Reset: arst_n clears all control state and the valid marks at once; the
// position RAM is not cleared and is only trusted where its valid mark is set.
module longest_unique_char_window #(
	parameter int ALPHABET_SIZE = 256,
	parameter int MAX_LEN       = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  lucw_pkg::in_word_t   char_word,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lucw_pkg::out_word_t  result_word
);
	import lucw_pkg::*;

	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam int POS_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	// Position table and valid marks
	logic [POS_W-1:0]         pos_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] seen_valid_q;

	// Window state
	logic [POS_W-1:0] ws_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] best_q;
	logic             overflow_q;

	// Stage one
	logic             valid_s1;
	logic [IDX_W-1:0] code_s1;
	logic             last_s1;
	logic             fwd_s1;
	logic [POS_W-1:0] fwd_pos_s1;
	logic [POS_W-1:0] pos_rd_s1;

	logic             accept;
	logic [IDX_W-1:0] in_code;
	logic [POS_W-1:0] pos_cur;
	logic             ovf;
	logic             hit;
	logic             wr;
	logic [POS_W-1:0] ws_next;
	logic [CNT_W-1:0] win;
	logic [CNT_W-1:0] best_next;
	out_word_t        res_word;
	logic [FILL_W-1:0] fill;

	// Accept while the result queue can hold everything in flight
	assign char_ready = ((3'(fill) + 3'(valid_s1)) < 3'(FIFO_DEPTH));
	assign accept     = char_valid && char_ready;

	// Fold the byte into the alphabet through a constant table
	always_comb begin
		in_code = '0;
		for (int v = 0; v < (1 << CHAR_W); v++) begin
			if (char_word.char_code == CHAR_W'(v)) begin
				in_code = IDX_W'(v % ALPHABET_SIZE);
			end
		end
	end

	// Resolve the window for the byte in stage one
	always_comb begin
		pos_cur   = fwd_s1 ? fwd_pos_s1 : pos_rd_s1;
		ovf       = (cnt_q >= CNT_W'(MAX_LEN));
		hit       = seen_valid_q[code_s1] && (pos_cur >= ws_q);
		ws_next   = hit ? POS_W'({1'b0, pos_cur} + 1'b1) : ws_q;
		if (ovf) begin
			win = cnt_q - CNT_W'(ws_q);
		end else begin
			win = cnt_q - CNT_W'(ws_next) + 1'b1;
		end
		best_next = (!ovf && (win > best_q)) ? win : best_q;
		wr        = valid_s1 && !ovf;
	end

	always_comb begin
		res_word.best_length   = LEN_W'(best_next);
		res_word.window_length = LEN_W'(win);
		res_word.final_flag    = last_s1;
		res_word.overflow      = ovf || overflow_q;
	end

	// Write back the position and read the next byte's entry
	always_ff @(posedge clk) begin
		if (wr) begin
			pos_mem[code_s1] <= cnt_q[POS_W-1:0];
		end
		if (accept) begin
			pos_rd_s1 <= pos_mem[in_code];
		end
	end

	// Capture the accepted byte and forward a same-entry write
	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1    <= in_code;
			last_s1    <= char_word.is_last;
			fwd_pos_s1 <= cnt_q[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && wr && (code_s1 == in_code);
		end
	end

	// Commit window state, then drop it all after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_valid_q <= '0;
			ws_q         <= '0;
			cnt_q        <= '0;
			best_q       <= '0;
			overflow_q   <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				seen_valid_q <= '0;
				ws_q         <= '0;
				cnt_q        <= '0;
				best_q       <= '0;
				overflow_q   <= 1'b0;
			end else begin
				if (wr) begin
					seen_valid_q[code_s1] <= 1'b1;
					ws_q                  <= ws_next;
					cnt_q                 <= cnt_q + 1'b1;
				end
				best_q     <= best_next;
				overflow_q <= overflow_q || ovf;
			end
		end
	end

	lucw_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_word (res_word),
		.pop_valid (result_valid),
		.pop_ready (result_ready),
		.pop_word  (result_word),
		.fill      (fill)
	);

	// Checks
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (fill < FILL_W'(FIFO_DEPTH)))
		else $error("result queue has no room for stage one word");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> ((cnt_q == '0) && (seen_valid_q == '0)))
		else $error("state not cleared after last byte");

	a_start_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(ws_q) <= cnt_q)
		else $error("window start beyond position count");

	a_fwd_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forward flag set with empty stage one");

endmodule

>>> sim/lucw_checker.sv
`timescale 1ns / 1ps

module lucw_checker #(
	parameter int ALPHABET_SIZE = 256,
	parameter int MAX_LEN       = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	input  logic                char_ready,
	input  lucw_pkg::in_word_t  char_word,
	input  logic                result_valid,
	input  logic                result_ready,
	input  lucw_pkg::out_word_t result_word,
	output int                  mismatch_count,
	output int                  results_pending
);

	import lucw_pkg::*;

	localparam int REPORT_CAP = 40;

	// Shadow copy of the window state
	logic             seen_valid [ALPHABET_SIZE];
	logic [LEN_W-1:0] seen_pos   [ALPHABET_SIZE];
	logic [LEN_W-1:0] win_start;
	logic [LEN_W-1:0] byte_count;
	logic [LEN_W-1:0] best_len;
	logic             overflow_seen;

	out_word_t expected_words[$];
	int        failures = 0;

	// Drop the valid marks and the window; the position table is only read where marked
	function automatic void clear_window();
		foreach (seen_valid[i])
			seen_valid[i] = 1'b0;
		win_start     = '0;
		byte_count    = '0;
		best_len      = '0;
		overflow_seen = 1'b0;
	endfunction

	// Advance the window by one byte and form the result word it yields
	function automatic out_word_t advance_window(in_word_t w);
		int               code;
		logic [LEN_W-1:0] win;
		out_word_t        r;
		code = int'(w.char_code) % ALPHABET_SIZE;
		if (byte_count >= MAX_LEN) begin
			// past the length limit: hold the window, only flag it
			overflow_seen = 1'b1;
			win = byte_count - win_start;
		end else begin
			if (seen_valid[code] && seen_pos[code] >= win_start)
				win_start = seen_pos[code] + 1'b1;
			win = byte_count - win_start + 1'b1;
			if (win > best_len)
				best_len = win;
			seen_pos[code]   = byte_count;
			seen_valid[code] = 1'b1;
			byte_count       = byte_count + 1'b1;
		end
		r.best_length   = best_len;
		r.window_length = win;
		r.final_flag    = w.is_last;
		r.overflow      = overflow_seen;
		if (w.is_last)
			clear_window();
		return r;
	endfunction

	function automatic bit field_ok(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
		if (want === got)
			return 1'b1;
		if (failures < REPORT_CAP)
			$display("%t %s: expected %0d, actual %0d", $time, name, want, got);
		return 1'b0;
	endfunction

	// Compare each delivered word with the oldest prediction, then log new bytes
	always @(posedge clk or negedge arst_n) begin : watch_words
		out_word_t want;
		bit        ok;
		if (!arst_n) begin
			clear_window();
			expected_words.delete();
			results_pending <= 0;
			mismatch_count  <= failures;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					if (failures < REPORT_CAP)
						$display("%t unexpected result word: expected none, actual %p",
							$time, result_word);
					failures++;
				end else begin
					want = expected_words.pop_front();
					ok = 1'b1;
					ok &= field_ok("best_length", want.best_length, result_word.best_length);
					ok &= field_ok("window_length", want.window_length,
						result_word.window_length);
					ok &= field_ok("final_flag", LEN_W'(want.final_flag),
						LEN_W'(result_word.final_flag));
					ok &= field_ok("overflow", LEN_W'(want.overflow),
						LEN_W'(result_word.overflow));
					if (!ok)
						failures++;
				end
			end
			if (char_valid && char_ready)
				expected_words.push_back(advance_window(char_word));
			results_pending <= expected_words.size();
			mismatch_count  <= failures;
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import lucw_pkg::*;

	localparam int ALPHABET_SIZE = 256;
	localparam int MAX_LEN       = 65536;
	localparam int PHASE_WORDS   = 550;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      char_valid;
	logic      char_ready;
	in_word_t  char_word;
	logic      result_valid;
	logic      result_ready;
	out_word_t result_word;

	int mismatch_count;
	int results_pending;

	int send_idle_pct   = 19;
	int recv_idle_pct   = 61;
	int hold_off_cycles = 0;

	always #5 clk = ~clk;

	longest_unique_char_window #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.MAX_LEN       (MAX_LEN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_word    (char_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	lucw_checker #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.MAX_LEN       (MAX_LEN)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_ready      (char_ready),
		.char_word       (char_word),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result_word     (result_word),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// Offer one byte after a random gap and hold it until taken; returns on a falling edge
	task automatic send_byte(input logic [CHAR_W-1:0] code, input logic last);
		in_word_t w;
		w.char_code = code;
		w.is_last   = last;
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_word  <= w;
		do
			@(posedge clk);
		while (!char_ready);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// Mix of short strings over a few letters, random bytes, and long rising walks
	task automatic send_random_strings(input int word_budget);
		int               sent;
		int               shape;
		int               len;
		int               span;
		logic [CHAR_W-1:0] base;
		logic [CHAR_W-1:0] code;
		sent = 0;
		while (sent < word_budget) begin
			shape = $urandom_range(9);
			base  = CHAR_W'($urandom);
			span  = $urandom_range(12, 2);
			len   = (shape == 0) ? $urandom_range(300, 250) : $urandom_range(40, 1);
			for (int i = 0; i < len; i++) begin
				if (shape == 0)
					code = base + CHAR_W'(i);
				else if (shape <= 5)
					code = base + CHAR_W'($urandom_range(span - 1));
				else
					code = CHAR_W'($urandom);
				send_byte(code, i == len - 1);
			end
			sent += len;
		end
	endtask

	// Idle the input, let every predicted word arrive, then retune the two sides
	task automatic close_phase(input int send_pct, input int recv_pct, input int stall);
		char_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		send_idle_pct   = send_pct;
		recv_idle_pct   = recv_pct;
		hold_off_cycles = stall;
		@(negedge clk);
	endtask

	// Receiver: random back-pressure, or a counted hold-off when one is requested
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				result_ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Give up on a hung run
	initial begin
		#4_000_000;
		$display("longest_unique_char_window: mismatch");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_word  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-byte string
		send_byte(8'h00, 1'b1);
		// repeats inside the window, including back-to-back
		send_text("abcabcbb");
		// earlier occurrence already left of the window
		send_text("abba");
		// byte extremes
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		// marks from the last string must be gone
		send_text("ab");

		send_random_strings(PHASE_WORDS);
		close_phase(61, 19, 0);
		send_random_strings(PHASE_WORDS);
		// long receiver hold-off while the sender keeps pushing
		close_phase(0, 0, 80);
		send_random_strings(PHASE_WORDS);
		close_phase(0, 0, 0);

		// one more short string with a repeat
		send_text("aba");
		close_phase(0, 0, 0);

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("longest_unique_char_window: match");
		else
			$display("longest_unique_char_window: mismatch");
		$finish;
	end

endmodule
